@@ hdl/pcr_pkg.sv @@
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants of the PCM converter and resampler.
// ----------------------------------------------------------------------------
package pcr_pkg;

	// Register indexes of the configuration port
	localparam logic [7:0] REG_IS_FLOAT    = 8'd0;
	localparam logic [7:0] REG_SAMPLE_BITS = 8'd1;
	localparam logic [7:0] REG_STEREO      = 8'd2;
	localparam logic [7:0] REG_STEP        = 8'd3;

	// Register reset values
	localparam logic [6:0]  RST_SAMPLE_BITS = 7'd16;
	localparam logic [11:0] RST_STEP        = 12'd256;

	// Supported sample widths
	localparam logic [6:0] BITS_8  = 7'd8;
	localparam logic [6:0] BITS_16 = 7'd16;
	localparam logic [6:0] BITS_24 = 7'd24;
	localparam logic [6:0] BITS_32 = 7'd32;
	localparam logic [6:0] BITS_64 = 7'd64;

	// Resampler position: one source frame in 8.8, and the smallest step
	localparam logic [12:0] FRAME_ONE = 13'd256;
	localparam logic [11:0] MIN_STEP  = 12'd4;

	// Signed 16-bit limits
	localparam logic [15:0] S16_MAX = 16'h7FFF;
	localparam logic [15:0] S16_MIN = 16'h8000;

	// Conversion class of one word, fixed in the first converter stage
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_PCM,
		CLS_SAT,
		CLS_FLT
	} pcr_cls_t;

	// Configuration registers
	typedef struct packed {
		logic        is_float;
		logic [6:0]  sample_bits;
		logic        stereo;
		logic [11:0] step;
	} pcr_cfg_t;

	// Converted frame as queued between front and back
	typedef struct packed {
		logic        eos;
		logic [15:0] right;
		logic [15:0] left;
	} pcr_item_t;

endpackage

@@ hdl/pcr_conv.sv @@
// ----------------------------------------------------------------------------
// pcr_conv
// Two-stage converter of one raw sample word to signed 16 bits.
// ----------------------------------------------------------------------------
module pcr_conv (
	input  logic             clk,
	input  pcr_pkg::pcr_cfg_t cfg,
	input  logic [63:0]      word,
	output logic [15:0]      sample
);

	pcr_pkg::pcr_cls_t cls;
	logic              neg;
	logic [4:0]        shamt;
	logic [52:0]       mant;
	logic [15:0]       pcm;
	logic [67:0]       prod;

	pcr_pkg::pcr_cls_t cls_s2;
	logic              neg_s2;
	logic [4:0]        shamt_s2;
	logic [15:0]       val_s2;

	logic [15:0]       mag;

	// Classify the word and pick sign, shift and significand
	always_comb begin
		cls   = pcr_pkg::CLS_ZERO;
		neg   = 1'b0;
		shamt = 5'd0;
		mant  = '0;
		pcm   = '0;
		if (cfg.is_float) begin
			if (cfg.sample_bits == pcr_pkg::BITS_64) begin
				neg  = word[63];
				mant = {1'b1, word[51:0]};
				if (word[62:52] == 11'h7FF && word[51:0] != '0) begin
					cls = pcr_pkg::CLS_ZERO;
				end else if (word[62:52] == 11'd0) begin
					cls = pcr_pkg::CLS_ZERO;
				end else if (word[62:52] >= 11'd1024) begin
					cls = pcr_pkg::CLS_SAT;
				end else if (word[62:52] < 11'd1007) begin
					cls = pcr_pkg::CLS_ZERO;
				end else begin
					cls   = pcr_pkg::CLS_FLT;
					shamt = 5'(11'd1023 - word[62:52]);
				end
			end else if (cfg.sample_bits == pcr_pkg::BITS_32) begin
				neg  = word[31];
				mant = {1'b1, word[22:0], 29'd0};
				if (word[30:23] == 8'hFF && word[22:0] != '0) begin
					cls = pcr_pkg::CLS_ZERO;
				end else if (word[30:23] == 8'd0) begin
					cls = pcr_pkg::CLS_ZERO;
				end else if (word[30:23] >= 8'd128) begin
					cls = pcr_pkg::CLS_SAT;
				end else if (word[30:23] < 8'd111) begin
					cls = pcr_pkg::CLS_ZERO;
				end else begin
					cls   = pcr_pkg::CLS_FLT;
					shamt = 5'(8'd127 - word[30:23]);
				end
			end
		end else begin
			cls = pcr_pkg::CLS_PCM;
			case (cfg.sample_bits)
				pcr_pkg::BITS_8: begin
					pcm = {~word[7], word[6:0], 8'd0};
				end
				pcr_pkg::BITS_16: begin
					pcm = word[15:0];
				end
				pcr_pkg::BITS_24: begin
					pcm = word[23:8];
				end
				pcr_pkg::BITS_32: begin
					pcm = word[31:16];
				end
				default: begin
					cls = pcr_pkg::CLS_ZERO;
				end
			endcase
		end
	end

	// Scale by 32767 as a shift and subtract
	assign prod = {mant, 15'd0} - {15'd0, mant};

	// Register class, sign, shift and the PCM value or the integer part of the scaled significand
	always_ff @(posedge clk) begin
		cls_s2   <= cls;
		neg_s2   <= neg;
		shamt_s2 <= shamt;
		val_s2   <= (cls == pcr_pkg::CLS_PCM) ? pcm : prod[67:52];
	end

	// Align by the exponent, then saturate and apply the sign
	assign mag = val_s2 >> shamt_s2;

	always_comb begin
		case (cls_s2)
			pcr_pkg::CLS_PCM: begin
				sample = val_s2;
			end
			pcr_pkg::CLS_SAT: begin
				sample = neg_s2 ? pcr_pkg::S16_MIN : pcr_pkg::S16_MAX;
			end
			pcr_pkg::CLS_FLT: begin
				if (neg_s2) begin
					sample = mag[15] ? pcr_pkg::S16_MIN : (~mag + 16'd1);
				end else begin
					sample = mag[15] ? pcr_pkg::S16_MAX : mag;
				end
			end
			default: begin
				sample = '0;
			end
		endcase
	end

endmodule

@@ hdl/pcr_front.sv @@
// ----------------------------------------------------------------------------
// pcr_front
// Input side: accepts source frames and converts both channels in two stages.
// ----------------------------------------------------------------------------
module pcr_front #(
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pcr_pkg::pcr_cfg_t         cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [63:0]               left_raw,
	input  logic [63:0]               right_raw,
	input  logic                      end_of_stream,
	input  logic [$clog2(DEPTH+1)-1:0] level,
	output logic                      push,
	output pcr_pkg::pcr_item_t        push_item
);

	localparam int LW = $clog2(DEPTH + 1);

	logic              v_s1;
	logic              v_s2;
	logic              eos_s1;
	logic              eos_s2;
	logic [63:0]       left_s1;
	logic [63:0]       right_s1;
	logic [LW:0]       claimed;
	logic [15:0]       left_cv;
	logic [15:0]       right_cv;
	logic              accept;

	// Count queue entries plus frames still in conversion
	assign claimed  = {1'b0, level} + (LW+1)'(v_s1) + (LW+1)'(v_s2);
	assign in_ready = (claimed < (LW+1)'(DEPTH));
	assign accept   = in_valid && in_ready;

	// Advance the valid bits of the conversion pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Register the input payload every cycle; the valid bit marks an accepted one
	always_ff @(posedge clk) begin
		left_s1  <= left_raw;
		right_s1 <= right_raw;
		eos_s1   <= end_of_stream;
		eos_s2   <= eos_s1;
	end

	pcr_conv u_conv_left (
		.clk    (clk),
		.cfg    (cfg),
		.word   (left_s1),
		.sample (left_cv)
	);

	pcr_conv u_conv_right (
		.clk    (clk),
		.cfg    (cfg),
		.word   (right_s1),
		.sample (right_cv)
	);

	// Push the converted frame; mono drops the right channel
	assign push            = v_s2;
	assign push_item.left  = left_cv;
	assign push_item.right = cfg.stereo ? right_cv : 16'd0;
	assign push_item.eos   = eos_s2;

endmodule

@@ hdl/pcr_fifo.sv @@
// ----------------------------------------------------------------------------
// pcr_fifo
// Short queue of converted frames between the front and the back.
// ----------------------------------------------------------------------------
module pcr_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  pcr_pkg::pcr_item_t         push_item,
	input  logic                       pop,
	output logic                       head_valid,
	output pcr_pkg::pcr_item_t         head_item,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	pcr_pkg::pcr_item_t entry_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [LW-1:0]      count_q;
	logic               do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign level      = count_q;

	// Store pushed frames
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + LW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - LW'(1);
			end
		end
	end

endmodule

@@ hdl/pcr_back.sv @@
// ----------------------------------------------------------------------------
// pcr_back
// Output side: repeats each queued frame by the 8.8 step accumulator.
// ----------------------------------------------------------------------------
module pcr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pcr_pkg::pcr_cfg_t  cfg,
	input  logic               head_valid,
	input  pcr_pkg::pcr_item_t head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        left_out,
	output logic [15:0]        right_out,
	output logic               run_last
);

	logic [12:0] pos_q;
	logic        out_valid_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic        last_q;

	logic [11:0] st;
	logic [12:0] nxt;
	logic        slot_free;
	logic        skip;
	logic        emit;
	logic        done;

	// Clamp the step and form the next position
	assign st        = (cfg.step < pcr_pkg::MIN_STEP) ? pcr_pkg::MIN_STEP : cfg.step;
	assign nxt       = pos_q + {1'b0, st};
	assign slot_free = !out_valid_q || out_ready;

	// A frame already passed emits nothing; otherwise emit one copy per cycle while the output slot is free
	assign skip = head_valid && (pos_q >= pcr_pkg::FRAME_ONE);
	assign emit = head_valid && (pos_q < pcr_pkg::FRAME_ONE) && slot_free;
	assign done = nxt >= pcr_pkg::FRAME_ONE;
	assign pop  = skip || (emit && done);

	// Track the position of the next output frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (skip) begin
			pos_q <= head_item.eos ? '0 : pos_q - pcr_pkg::FRAME_ONE;
		end else if (emit) begin
			if (done) begin
				pos_q <= head_item.eos ? '0 : nxt - pcr_pkg::FRAME_ONE;
			end else begin
				pos_q <= nxt;
			end
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_q  <= head_item.left;
			right_q <= head_item.right;
			last_q  <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign run_last  = last_q;

endmodule

@@ hdl/pcm_convert_resample.sv @@
// First output frame passes the input, converter, queue and output registers after acceptance.
// Back end emits one output frame per cycle unless stalled; an input that yields none is skipped.
// Front end converts one input per cycle while the frame queue has room (DEPTH entries).
// Sustained rate is set by the back end, which pops a queued frame with its last output or skip.
// Reset clears the pipeline, queue, position and restores register defaults.
// ----------------------------------------------------------------------------
// pcm_convert_resample
// PCM/float to signed 16-bit converter with sample-and-hold (floor position) resampling.
// ----------------------------------------------------------------------------
module pcm_convert_resample #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	// Input stream
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // [63:0] left_raw, [127:64] right_raw
	input  logic          s_axis_tlast,  // end_of_stream
	// Output stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,  // [15:0] left_out, [31:16] right_out
	output logic          m_axis_tlast,  // run_last
	// Configuration writes
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [11:0]   cfg_data
);

	localparam int LW = $clog2(DEPTH + 1);

	pcr_pkg::pcr_cfg_t  cfg_q;
	logic               push;
	pcr_pkg::pcr_item_t push_item;
	logic               pop;
	logic               head_valid;
	pcr_pkg::pcr_item_t head_item;
	logic [LW-1:0]      level;
	logic [15:0]        left_out;
	logic [15:0]        right_out;

	// Configuration registers; writes to unknown indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_float    <= 1'b0;
			cfg_q.sample_bits <= pcr_pkg::RST_SAMPLE_BITS;
			cfg_q.stereo      <= 1'b1;
			cfg_q.step        <= pcr_pkg::RST_STEP;
		end else if (cfg_valid) begin
			case (cfg_index)
				pcr_pkg::REG_IS_FLOAT: begin
					cfg_q.is_float <= cfg_data[0];
				end
				pcr_pkg::REG_SAMPLE_BITS: begin
					cfg_q.sample_bits <= cfg_data[6:0];
				end
				pcr_pkg::REG_STEREO: begin
					cfg_q.stereo <= cfg_data[0];
				end
				pcr_pkg::REG_STEP: begin
					cfg_q.step <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	pcr_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.left_raw      (s_axis_tdata[63:0]),
		.right_raw     (s_axis_tdata[127:64]),
		.end_of_stream (s_axis_tlast),
		.level         (level),
		.push          (push),
		.push_item     (push_item)
	);

	pcr_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.level      (level)
	);

	pcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.left_out   (left_out),
		.right_out  (right_out),
		.run_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {right_out, left_out};

endmodule

@@ tb/pcr_resample_monitor.sv @@
// ----------------------------------------------------------------------------
// pcr_resample_monitor
// Watches the configuration, input and output channels of the PCM converter
// and resampler. It keeps its own register copy and resampling position,
// predicts the output frames of every accepted input transaction, and
// compares each accepted output frame with the oldest prediction.
// ----------------------------------------------------------------------------
module pcr_resample_monitor (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] left_raw, [127:64] right_raw
	input  logic         s_axis_tlast,  // end_of_stream
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [31:0]  m_axis_tdata,  // [15:0] left_out, [31:16] right_out
	input  logic         m_axis_tlast,  // run_last
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [11:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	localparam logic [63:0] FULL_SCALE  = 64'd32767;
	localparam int          MAX_REPEATS = 64;
	localparam int          SHOWN_FAILS = 10;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} out_frame_t;

	pcr_pkg::pcr_cfg_t regs;
	logic [12:0] frame_pos;
	out_frame_t frames_due[$];

	// Scale a float by full scale, truncate toward zero and saturate.
	// mant carries the hidden bit at position 52; value = mant * 2^(ue-52).
	function automatic logic [15:0] scale_float(input logic neg, input int ue,
			input logic [63:0] mant);
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] mag;
		if (ue >= 1) begin
			mag = 64'd65536;
		end else if (ue < -16) begin
			mag = 64'd0;
		end else begin
			// split the product so it fits 64 bits, then drop 52 - ue bits
			hi  = (mant >> 20) * FULL_SCALE;
			lo  = (mant & 64'hF_FFFF) * FULL_SCALE;
			mag = (hi + (lo >> 20)) >> (32 - ue);
		end
		if (neg) begin
			if (mag >= 64'd32768)
				return pcr_pkg::S16_MIN;
			return 16'h0000 - mag[15:0];
		end
		if (mag > FULL_SCALE)
			return pcr_pkg::S16_MAX;
		return mag[15:0];
	endfunction

	// Convert one raw sample word to signed 16 bits under the given settings
	function automatic logic [15:0] convert_word(input pcr_pkg::pcr_cfg_t c,
			input logic [63:0] w);
		if (c.is_float) begin
			if (c.sample_bits == pcr_pkg::BITS_64) begin
				// NaN and zero/subnormal give 0
				if (w[62:52] == 11'h7FF && w[51:0] != 52'd0)
					return 16'h0000;
				if (w[62:52] == 11'h000)
					return 16'h0000;
				return scale_float(w[63], int'(w[62:52]) - 1023, {11'b0, 1'b1, w[51:0]});
			end
			if (c.sample_bits == pcr_pkg::BITS_32) begin
				if (w[30:23] == 8'hFF && w[22:0] != 23'd0)
					return 16'h0000;
				if (w[30:23] == 8'h00)
					return 16'h0000;
				return scale_float(w[31], int'(w[30:23]) - 127,
					{11'b0, 1'b1, w[22:0], 29'b0});
			end
			return 16'h0000;
		end
		case (c.sample_bits)
			pcr_pkg::BITS_8:  return {w[7:0] ^ 8'h80, 8'h00};
			pcr_pkg::BITS_16: return w[15:0];
			pcr_pkg::BITS_24: return w[23:8];
			pcr_pkg::BITS_32: return w[31:16];
			default:          return 16'h0000;
		endcase
	endfunction

	// Track registers and position, queue predictions, check output frames
	always @(posedge clk or negedge arst_n) begin : watch
		logic [15:0] left_s16;
		logic [15:0] right_s16;
		int          pos;
		int          stride;
		int          n;
		out_frame_t  got;
		out_frame_t  want;
		if (!arst_n) begin
			regs.is_float    = 1'b0;
			regs.sample_bits = pcr_pkg::RST_SAMPLE_BITS;
			regs.stereo      = 1'b1;
			regs.step        = pcr_pkg::RST_STEP;
			frame_pos        = 13'd0;
			frames_due.delete();
			fail_count       = 0;
			pending         <= 0;
		end else begin
			// apply a register write transaction; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pcr_pkg::REG_IS_FLOAT:    regs.is_float    = cfg_data[0];
					pcr_pkg::REG_SAMPLE_BITS: regs.sample_bits = cfg_data[6:0];
					pcr_pkg::REG_STEREO:      regs.stereo      = cfg_data[0];
					pcr_pkg::REG_STEP:        regs.step        = cfg_data;
					default: ;
				endcase
			end

			// predict the repeats of an accepted source frame
			if (s_axis_tvalid && s_axis_tready) begin
				left_s16  = convert_word(regs, s_axis_tdata[63:0]);
				right_s16 = regs.stereo ? convert_word(regs, s_axis_tdata[127:64]) : 16'h0000;
				stride    = (regs.step < pcr_pkg::MIN_STEP) ? int'(pcr_pkg::MIN_STEP) :
					int'(regs.step);
				pos       = int'(frame_pos);
				n         = 0;
				while (pos < int'(pcr_pkg::FRAME_ONE) && n < MAX_REPEATS) begin
					frames_due.push_back('{left: left_s16, right: right_s16,
						last: (pos + stride >= int'(pcr_pkg::FRAME_ONE)) ||
							(n == MAX_REPEATS - 1)});
					n++;
					pos += stride;
				end
				frame_pos = s_axis_tlast ? 13'd0 : 13'(pos - int'(pcr_pkg::FRAME_ONE));
			end

			// compare an accepted output frame with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{left: m_axis_tdata[15:0], right: m_axis_tdata[31:16],
					last: m_axis_tlast};
				if (frames_due.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOWN_FAILS)
						$display("unexpected output frame: left %h right %h last %b",
							got.left, got.right, got.last);
				end else begin
					want = frames_due.pop_front();
					if (got.left !== want.left || got.right !== want.right ||
							got.last !== want.last) begin
						fail_count++;
						if (fail_count <= SHOWN_FAILS)
							$display({"output frame mismatch: expected left %h right %h last %b,",
								" got left %h right %h last %b"}, want.left, want.right,
								want.last, got.left, got.right, got.last);
					end
				end
			end
			pending <= frames_due.size();
		end
	end

endmodule

@@ tb/pcm_convert_resample_test.sv @@
// ----------------------------------------------------------------------------
// pcm_convert_resample_test
// Drives the PCM converter and resampler through directed frames and random
// traffic under several register settings: every sample format, mono and
// stereo, the smallest and largest step, masked and out-of-range register
// writes. Both stream sides idle and stall at random; a long output hold-off
// fills the block. The monitor beside the block predicts and checks.
// ----------------------------------------------------------------------------
module pcm_convert_resample_test;

	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         SETTLE_CYCLES = 20;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         STALL_PCT     = 63;
	localparam int         BOTH_PCT      = 32;
	localparam logic [7:0] REG_UNUSED    = 8'd7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata  = '0;   // [63:0] left_raw, [127:64] right_raw
	logic         s_axis_tlast  = 1'b0; // end_of_stream
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;         // [15:0] left_out, [31:16] right_out
	logic         m_axis_tlast;         // run_last
	logic         cfg_valid     = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index     = '0;
	logic [11:0]  cfg_data      = '0;

	int   fail_count;
	int   pending;
	logic in_fire      = 1'b0;
	logic cfg_fire     = 1'b0;
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	logic hold_go      = 1'b0;
	logic hold_taken   = 1'b0;
	int   hold_left    = 0;
	int   cycle_count  = 0;
	logic       cur_float = 1'b0;
	logic [6:0] cur_bits  = pcr_pkg::RST_SAMPLE_BITS;

	pcm_convert_resample DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pcr_resample_monitor u_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Record accepted transactions for the driving tasks
	always @(posedge clk) begin
		in_fire  <= s_axis_tvalid && s_axis_tready;
		cfg_fire <= cfg_valid && cfg_ready;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_go && !hold_taken) begin
			m_axis_tready <= 1'b0;
			hold_left     <= HOLD_CYCLES;
			hold_taken    <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin tx_idle_pct = 0;         rx_stall_pct <= 0;         end
			IDLE_SENDER:   begin tx_idle_pct = STALL_PCT; rx_stall_pct <= 0;         end
			IDLE_RECEIVER: begin tx_idle_pct = 0;         rx_stall_pct <= STALL_PCT; end
			default:       begin tx_idle_pct = BOTH_PCT;  rx_stall_pct <= BOTH_PCT;  end
		endcase
	endtask

	// Offer one source frame after random gaps and hold it until accepted
	task automatic send_frame(input logic [63:0] left_w, input logic [63:0] right_w,
			input logic eos);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {right_w, left_w};
		s_axis_tlast  <= eos;
		do @(negedge clk); while (!in_fire);
	endtask

	// Stop sending and wait until every predicted frame has come out
	task automatic wait_drained(input int extra);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_fire);
	endtask

	// Rewrite all registers once the block is idle
	task automatic configure(input logic [11:0] float_val, input logic [11:0] width_val,
			input logic [11:0] stereo_val, input logic [11:0] step_val,
			input bit poke_unused);
		wait_drained(SETTLE_CYCLES);
		write_reg(pcr_pkg::REG_IS_FLOAT, float_val);
		write_reg(pcr_pkg::REG_SAMPLE_BITS, width_val);
		write_reg(pcr_pkg::REG_STEREO, stereo_val);
		write_reg(pcr_pkg::REG_STEP, step_val);
		if (poke_unused)
			write_reg(REG_UNUSED, 12'hFFF);
		cfg_valid <= 1'b0;
		cur_float = float_val[0];
		cur_bits  = width_val[6:0];
	endtask

	// Float word with the exponent mostly in the range that converts
	function automatic logic [63:0] rand_float(input bit wide);
		logic [63:0] w;
		int          ue;
		w  = {$urandom, $urandom};
		ue = int'($urandom_range(0, 20)) - 18;
		case ($urandom_range(0, 9))
			0: ue = wide ? -1023 : -127; // zero or subnormal
			1: ue = wide ? 1024 : 128;   // infinity or NaN
			default: ;
		endcase
		if (wide)
			w[62:52] = 11'(ue + 1023);
		else
			w[30:23] = 8'(ue + 127);
		// exact powers of two, zeros and infinities
		if ($urandom_range(0, 3) == 0) begin
			if (wide)
				w[51:0] = '0;
			else
				w[22:0] = '0;
		end
		return w;
	endfunction

	function automatic logic [63:0] sample_word();
		if (!cur_float || $urandom_range(0, 7) == 0)
			return {$urandom, $urandom};
		return rand_float(cur_bits == pcr_pkg::BITS_64);
	endfunction

	task automatic send_random(input int count);
		repeat (count)
			send_frame(sample_word(), sample_word(), $urandom_range(0, 7) == 0);
	endtask

	function automatic logic [11:0] pick_width();
		case ($urandom_range(0, 5))
			0:       return 12'(pcr_pkg::BITS_8);
			1:       return 12'(pcr_pkg::BITS_16);
			2:       return 12'(pcr_pkg::BITS_24);
			3:       return 12'(pcr_pkg::BITS_32);
			4:       return 12'(pcr_pkg::BITS_64);
			default: return 12'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [11:0] pick_step();
		if ($urandom_range(0, 3) == 0)
			return 12'($urandom_range(0, 40));
		return 12'($urandom_range(64, 900));
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: 16-bit stereo at unit step, with a drain mid-way
		set_idle(IDLE_NONE);
		send_frame(64'h7FFF, 64'h8000, 1'b0);
		send_frame('1, 64'h0, 1'b1);
		send_random(15);
		wait_drained(0);
		send_random(15);

		// 8-bit unsigned mono from over-wide writes, plus an unknown index
		configure(12'hFFE, 12'hF88, 12'hFFE, 12'd171, 1'b1);
		set_idle(IDLE_SENDER);
		send_frame(64'h0, '1, 1'b0);
		send_frame(64'hFF, 64'h0, 1'b0);
		send_frame(64'h80, 64'h0, 1'b1);
		send_random(25);

		// 24-bit stereo, one output per two inputs
		configure(12'd0, 12'(pcr_pkg::BITS_24), 12'd1, 12'd512, 1'b0);
		set_idle(IDLE_RECEIVER);
		send_frame(64'h7F_FFFF, 64'h80_0000, 1'b0);
		send_random(25);

		// 32-bit stereo at the largest step
		configure(12'd0, 12'(pcr_pkg::BITS_32), 12'd1, 12'd4095, 1'b0);
		set_idle(IDLE_BOTH);
		send_frame(64'h7FFF_FFFF, 64'h8000_0000, 1'b1);
		send_random(25);

		// PCM width that is not supported
		configure(12'd0, 12'd12, 12'd1, 12'd256, 1'b0);
		send_frame('1, '1, 1'b0);
		send_random(5);

		// single precision; long output hold-off fills the block
		configure(12'd1, 12'(pcr_pkg::BITS_32), 12'd1, 12'd200, 1'b0);
		set_idle(IDLE_NONE);
		send_frame(64'h7FC0_0000, 64'h7F80_0000, 1'b0); // NaN, +inf
		send_frame(64'hFF80_0000, 64'h0000_0001, 1'b0); // -inf, subnormal
		send_frame(64'h3F00_0000, 64'hBF80_0000, 1'b0); // 0.5, -1.0
		send_frame(64'h4000_0000, 64'h3380_0000, 1'b0); // 2.0, tiny
		hold_go <= 1'b1;
		send_random(30);

		// double precision stereo
		configure(12'd1, 12'(pcr_pkg::BITS_64), 12'd1, 12'd333, 1'b0);
		set_idle(IDLE_SENDER);
		send_frame(64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0);
		send_frame(64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0);
		send_frame(64'h3FE0_0000_0000_0000, 64'hBFE8_0000_0000_0000, 1'b1);
		send_random(30);

		// float with a width that is not supported
		configure(12'd1, 12'(pcr_pkg::BITS_16), 12'd1, 12'd256, 1'b0);
		send_frame(64'h3FF0_0000_0000_0000, 64'h3F80_0000, 1'b0);
		send_random(4);

		// step below the floor: every mono frame repeats the most times
		configure(12'd0, 12'(pcr_pkg::BITS_16), 12'd0, 12'd0, 1'b0);
		set_idle(IDLE_RECEIVER);
		send_frame(64'h1234, 64'h5678, 1'b0);
		send_random(4);

		// random settings across all idle modes
		for (int k = 0; k < 4; k++) begin
			configure(12'($urandom_range(0, 1)), pick_width(), 12'($urandom_range(0, 1)),
				pick_step(), 1'b0);
			set_idle(idle_mode_t'(k));
			send_random(12);
		end

		wait_drained(40);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
